/* rtl/core/fpa_pkg.sv */
// ---------------------------------------------------------------------------
// fpa_pkg
// Shared opcodes, status codes, pipeline sideband type and the saturation
// helper for the fixed-point ALU.
// ---------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_CMP      = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_TO_INT   = 4'd10
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  localparam logic [31:0] FX_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] FX_MIN = 32'h8000_0000;

  // per-transaction data that travels beside the divider stages
  typedef struct packed {
    logic [3:0]  op;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] res;
    logic [1:0]  st;
    logic        neg;
    logic        bzero;
    logic [63:0] mres;
  } sb_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // signed result from a magnitude and a sign, clamped to 32 bits
  function automatic sat_t sat_mag(input logic [63:0] mag, input logic neg);
    sat_t r;
    r.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.res = FX_MIN;
        r.ovf = 1'b1;
      end else begin
        r.res = 32'(-mag[31:0]);
      end
    end else begin
      if (mag > 64'h0000_0000_7FFF_FFFF) begin
        r.res = FX_MAX;
        r.ovf = 1'b1;
      end else begin
        r.res = mag[31:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/fpa_div.sv */
// ---------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Gives the quotient and remainder from the last stage register; every stage advances only while en is high.
// ---------------------------------------------------------------------------
`default_nettype none

module fpa_div
  import fpa_pkg::*;
#(
  parameter int NW = 40
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [31:0]   den,
  output logic      [NW-1:0] quo,
  output logic      [31:0]   rem
);

  logic [31:0]   rem_q [NW];
  logic [NW-1:0] qn_q  [NW];
  logic [31:0]   den_q [NW];

  genvar i;
  generate
    for (i = 0; i < NW; i++) begin : g_stage
      logic [31:0]   rem_p;
      logic [NW-1:0] qn_p;
      logic [31:0]   den_p;
      logic [32:0]   trial;
      logic [32:0]   diff;
      logic          ge;

      if (i == 0) begin : g_first
        assign rem_p = '0;
        assign qn_p  = num;
        assign den_p = den;
      end else begin : g_next
        assign rem_p = rem_q[i-1];
        assign qn_p  = qn_q[i-1];
        assign den_p = den_q[i-1];
      end

      // shift in the next dividend bit and try the subtract
      assign trial = {rem_p, qn_p[NW-1]};
      assign diff  = trial - {1'b0, den_p};
      assign ge    = (trial >= {1'b0, den_p});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= ge ? diff[31:0] : trial[31:0];
          qn_q[i]  <= {qn_p[NW-2:0], ge};
          den_q[i] <= den_p;
        end
      end
    end
  endgenerate

  assign quo = qn_q[NW-1];
  assign rem = rem_q[NW-1];

endmodule

`default_nettype wire

/* rtl/core/fixed_point_alu_core.sv */
// ---------------------------------------------------------------------------
// fixed_point_alu_core
// Signed Q(32-F).F fixed-point ALU with saturation, rounded multiply and
// divide, and comparison flags on every transaction.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_stall    opcode, operand_a, operand_b
//  out      out_valid/out_stall  result_value, a_greater, a_less, a_equal, status
//
//  one transaction enters per cycle while in_stall is low; the pipeline is the
//  input register, 32 + FRAC_BITS divider stages and the output register.
//  the bit-per-stage divider sets the latency.
//  the whole pipeline holds while a result waits with out_stall high.
//  rst clears all valid bits synchronously.
// ---------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_core
  import fpa_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      result_value,
  output logic             a_greater,
  output logic             a_less,
  output logic             a_equal,
  output logic [1:0]       status
);

  localparam int NW = 32 + FRAC_BITS;
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input decode of the operations that need neither multiply nor divide
  logic signed [31:0] sa, sb_op;
  logic [32:0]        sum, dif, incv, decv;
  logic [63:0]        fi;
  sb_t                s0_next;
  logic [31:0]        mag_a_next, mag_b_next;

  assign sa    = operand_a;
  assign sb_op = operand_b;
  assign sum   = {operand_a[31], operand_a} + {operand_b[31], operand_b};
  assign dif   = {operand_a[31], operand_a} - {operand_b[31], operand_b};
  assign incv  = {operand_a[31], operand_a} + 33'd1;
  assign decv  = {operand_a[31], operand_a} - 33'd1;
  assign fi    = {{32{operand_a[31]}}, operand_a} << FRAC_BITS;

  always_comb begin
    s0_next       = '0;
    s0_next.op    = opcode;
    s0_next.gt    = sa > sb_op;
    s0_next.lt    = sa < sb_op;
    s0_next.eq    = operand_a == operand_b;
    s0_next.neg   = operand_a[31] ^ operand_b[31];
    s0_next.bzero = operand_b == 32'd0;
    s0_next.res   = '0;
    s0_next.st    = ST_OK;
    mag_a_next    = operand_a[31] ? 32'(-operand_a) : operand_a;
    mag_b_next    = operand_b[31] ? 32'(-operand_b) : operand_b;
    case (opcode)
      OP_ADD: begin
        s0_next.res = (sum[32] != sum[31]) ? (sum[32] ? FX_MIN : FX_MAX) : sum[31:0];
        s0_next.st  = (sum[32] != sum[31]) ? ST_OVF : ST_OK;
      end
      OP_SUB: begin
        s0_next.res = (dif[32] != dif[31]) ? (dif[32] ? FX_MIN : FX_MAX) : dif[31:0];
        s0_next.st  = (dif[32] != dif[31]) ? ST_OVF : ST_OK;
      end
      OP_INC: begin
        s0_next.res = (incv[32] != incv[31]) ? FX_MAX : incv[31:0];
        s0_next.st  = (incv[32] != incv[31]) ? ST_OVF : ST_OK;
      end
      OP_DEC: begin
        s0_next.res = (decv[32] != decv[31]) ? FX_MIN : decv[31:0];
        s0_next.st  = (decv[32] != decv[31]) ? ST_OVF : ST_OK;
      end
      OP_MIN:    s0_next.res = (sa < sb_op) ? operand_a : operand_b;
      OP_MAX:    s0_next.res = (sa > sb_op) ? operand_a : operand_b;
      OP_TO_INT: s0_next.res = 32'(sa >>> FRAC_BITS);
      OP_FROM_INT: begin
        if ((&fi[63:31]) || !(|fi[63:31])) begin
          s0_next.res = fi[31:0];
        end else begin
          s0_next.res = operand_a[31] ? FX_MIN : FX_MAX;
          s0_next.st  = ST_OVF;
        end
      end
      default: ;
    endcase
  end

  // input register
  sb_t         s0;
  logic        s0_valid;
  logic [31:0] s0_mag_a, s0_mag_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0       <= s0_next;
      s0_mag_a <= mag_a_next;
      s0_mag_b <= mag_b_next;
    end
  end

  // divider on magnitudes
  logic [NW-1:0] quo;
  logic [31:0]   rem;

  fpa_div #(.NW(NW)) u_div (
    .clk (clk),
    .en  (adv),
    .num ({s0_mag_a, {FRAC_BITS{1'b0}}}),
    .den (s0_mag_b),
    .quo (quo),
    .rem (rem)
  );

  // sideband line; multiply in its first stage, rounding in its second
  sb_t  sbq [NW];
  logic vld [NW];

  genvar i;
  generate
    for (i = 0; i < NW; i++) begin : g_sb
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else if (adv) begin
          vld[i] <= (i == 0) ? s0_valid : vld[(i == 0) ? 0 : i-1];
        end
      end
      if (i == 0) begin : g_mul
        sb_t stg_next;
        always_comb begin
          stg_next      = s0;
          stg_next.mres = 64'(s0_mag_a) * 64'(s0_mag_b);
        end
        always_ff @(posedge clk) begin
          if (adv) begin
            sbq[i] <= stg_next;
          end
        end
      end else if (i == 1) begin : g_rnd
        sb_t stg_next;
        always_comb begin
          stg_next      = sbq[i-1];
          stg_next.mres = (sbq[i-1].mres + HALF) >> FRAC_BITS;
        end
        always_ff @(posedge clk) begin
          if (adv) begin
            sbq[i] <= stg_next;
          end
        end
      end else begin : g_pass
        always_ff @(posedge clk) begin
          if (adv) begin
            sbq[i] <= sbq[i-1];
          end
        end
      end
    end
  endgenerate

  // final rounding, sign and saturation
  sb_t         last;
  logic        rnd_up;
  logic [63:0] qmag;
  sat_t        msat, dsat;
  logic [31:0] res_next;
  logic [1:0]  st_next;
  logic [31:0] u_div_den_last;

  assign last   = sbq[NW-1];
  assign rnd_up = {rem, 1'b0} >= {1'b0, u_div_den_last};
  assign qmag = 64'(quo) + 64'(rnd_up);
  assign msat = sat_mag(last.mres, last.neg);
  assign dsat = sat_mag(qmag, last.neg);

  // divisor magnitude aligned with the divider output
  logic [31:0] den_line [NW];
  generate
    for (i = 0; i < NW; i++) begin : g_den
      always_ff @(posedge clk) begin
        if (adv) begin
          den_line[i] <= (i == 0) ? s0_mag_b : den_line[(i == 0) ? 0 : i-1];
        end
      end
    end
  endgenerate
  assign u_div_den_last = den_line[NW-1];

  always_comb begin
    res_next = last.res;
    st_next  = last.st;
    case (last.op)
      OP_MUL: begin
        res_next = msat.res;
        st_next  = msat.ovf ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (last.bzero) begin
          res_next = '0;
          st_next  = ST_DIV0;
        end else begin
          res_next = dsat.res;
          st_next  = dsat.ovf ? ST_OVF : ST_OK;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= res_next;
      status       <= st_next;
      a_greater    <= last.gt;
      a_less       <= last.lt;
      a_equal      <= last.eq;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fpa_checker.sv */
// ---------------------------------------------------------------------------
// fpa_checker
// Port-level checks on the fixed-point ALU, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module fpa_checker
  import fpa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] result_value,
  input wire logic        a_greater,
  input wire logic        a_less,
  input wire logic        a_equal,
  input wire logic [1:0]  status
);

  // exactly one comparison flag per transaction
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_greater, a_less, a_equal}))
    else $error("comparison flags not one-hot");

  // divide by zero always yields zero
  a_div0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_DIV0) |-> (result_value == 32'd0))
    else $error("divide by zero result not zero");

  // no undefined status code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OVF || status == ST_DIV0))
    else $error("bad status code");

  // input holds exactly while a result is held back
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // stalled result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_value) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .result_value (result_value),
  .a_greater    (a_greater),
  .a_less       (a_less),
  .a_equal      (a_equal),
  .status       (status)
);

`default_nettype wire

/* verif/tb_fixed_point_alu_core.sv */
// ---------------------------------------------------------------------------
// tb_fixed_point_alu_core
// Self-checking bench for the Q24.8 fixed-point ALU: a directed table of
// operand extremes and special cases, then random transactions over several
// idle and stall phases, each result checked against an exact predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_point_alu_core;
  import fpa_pkg::*;

  localparam int FRAC = 8;

  typedef struct packed {
    logic [31:0] value;
    logic        gt;
    logic        lt;
    logic        eq;
    logic [1:0]  st;
  } alu_result_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic [31:0] value;
    logic [1:0]  st;
  } vector_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  opcode;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result_value;
  logic        a_greater;
  logic        a_less;
  logic        a_equal;
  logic [1:0]  status;

  alu_result_t pending_results[$];
  vector_t     vectors[$];
  int          mismatch_count;
  int          idle_pct;
  int          stall_pct;

  fixed_point_alu_core #(.FRAC_BITS(FRAC)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .a_greater(a_greater), .a_less(a_less),
    .a_equal(a_equal), .status(status)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // saturate a wide signed value to 32 bits
  function automatic logic [31:0] clamp_q(input longint v, inout logic [1:0] st);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      st = ST_OVF;
      return FX_MAX;
    end
    if (v < -longint'(64'h8000_0000)) begin
      st = ST_OVF;
      return FX_MIN;
    end
    return v[31:0];
  endfunction

  // exact fixed-point arithmetic for one transaction
  function automatic alu_result_t alu_predict(input logic [3:0] op, input logic [31:0] ra,
                                              input logic [31:0] rb);
    alu_result_t r;
    longint a;
    longint b;
    longint p;
    longint v;
    longint unsigned m;
    longint unsigned num;
    longint unsigned den;
    bit neg;
    a = longint'(signed'(ra));
    b = longint'(signed'(rb));
    r.st = ST_OK;
    v = 0;
    case (op)
      OP_ADD: v = a + b;
      OP_SUB: v = a - b;
      OP_MUL: begin
        p = a * b;
        neg = p < 0;
        m = neg ? -p : p;
        m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
        v = neg ? -longint'(m) : longint'(m);
      end
      OP_DIV: begin
        if (b != 0) begin
          neg = (a < 0) != (b < 0);
          num = longint'(a < 0 ? -a : a) << FRAC;
          den = b < 0 ? -b : b;
          m = (2 * num + den) / (2 * den);
          v = neg ? -longint'(m) : longint'(m);
        end
      end
      OP_INC: v = a + 1;
      OP_DEC: v = a - 1;
      OP_MIN: v = (a < b) ? a : b;
      OP_MAX: v = (a > b) ? a : b;
      OP_FROM_INT: v = a * (64'sd1 <<< FRAC);
      OP_TO_INT: v = a >>> FRAC;
      default: v = 0;
    endcase
    r.value = clamp_q(v, r.st);
    if (op == OP_DIV && b == 0) r.st = ST_DIV0;
    r.gt = a > b;
    r.lt = a < b;
    r.eq = a == b;
    return r;
  endfunction

  function automatic vector_t vec(input opcode_t op, input logic [31:0] a, input logic [31:0] b,
                                  input bit typed = 0, input logic [31:0] value = 0,
                                  input logic [1:0] st = ST_OK);
    vector_t t;
    t.op = op; t.a = a; t.b = b; t.typed = typed; t.value = value; t.st = st;
    return t;
  endfunction

  // drive one transaction and queue its expected result
  task automatic send(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(alu_predict(op, a, b));
    @(negedge clk);
  endtask

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %h got %h", what, exp_v, got_v);
  endtask

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    alu_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", 0, result_value);
      end else begin
        e = pending_results.pop_front();
        if (result_value !== e.value) report("result_value", e.value, result_value);
        if (a_greater !== e.gt) report("a_greater", e.gt, a_greater);
        if (a_less !== e.lt) report("a_less", e.lt, a_less);
        if (a_equal !== e.eq) report("a_equal", e.eq, a_equal);
        if (status !== e.st) report("status", e.st, status);
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return $urandom_range(2047) - 1024;
      1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      2: return $urandom_range(1) ? FX_MAX - $urandom_range(3) : FX_MIN + $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin
    logic [31:0] a;
    logic [31:0] b;
    alu_result_t e;
    rst = 1'b1; in_valid = 1'b0; opcode = '0; operand_a = '0; operand_b = '0;
    out_stall = 1'b0;
    idle_pct = 0; stall_pct = 0; mismatch_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table; typed rows carry their value and status
    vectors.push_back(vec(OP_ADD, FX_MAX, 32'd1, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_ADD, FX_MIN, FX_MIN, 1, FX_MIN, ST_OVF));
    vectors.push_back(vec(OP_SUB, FX_MIN, 32'd1, 1, FX_MIN, ST_OVF));
    vectors.push_back(vec(OP_SUB, FX_MAX, FX_MIN, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_MUL, FX_MAX, FX_MAX, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_MUL, FX_MIN, FX_MAX, 1, FX_MIN, ST_OVF));
    vectors.push_back(vec(OP_MUL, 32'h0000_0080, 32'h0000_0001));
    vectors.push_back(vec(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001));
    vectors.push_back(vec(OP_MUL, FX_MIN, FX_MIN, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_DIV, 32'h0000_0100, 32'd0, 1, 32'd0, ST_DIV0));
    vectors.push_back(vec(OP_DIV, FX_MIN, 32'd0, 1, 32'd0, ST_DIV0));
    vectors.push_back(vec(OP_DIV, FX_MIN, 32'hFFFF_FF00, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_DIV, FX_MAX, 32'd1, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_DIV, 32'd1, 32'd2));
    vectors.push_back(vec(OP_DIV, 32'hFFFF_FFFF, 32'd2));
    vectors.push_back(vec(OP_INC, FX_MAX, 32'd0, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_DEC, FX_MIN, 32'd0, 1, FX_MIN, ST_OVF));
    vectors.push_back(vec(OP_MIN, FX_MIN, FX_MAX, 1, FX_MIN, ST_OK));
    vectors.push_back(vec(OP_MAX, FX_MIN, FX_MAX, 1, FX_MAX, ST_OK));
    vectors.push_back(vec(OP_CMP, 32'd5, 32'd5, 1, 32'd0, ST_OK));
    vectors.push_back(vec(OP_FROM_INT, 32'h0080_0000, 32'd0, 1, FX_MAX, ST_OVF));
    vectors.push_back(vec(OP_FROM_INT, 32'hFF80_0000, 32'd0, 1, FX_MIN, ST_OK));
    vectors.push_back(vec(OP_TO_INT, FX_MIN, 32'd0, 1, 32'hFF80_0000, ST_OK));
    vectors.push_back(vec(OP_TO_INT, 32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF, ST_OK));
    foreach (vectors[i]) begin
      if (vectors[i].typed) begin
        e = alu_predict(vectors[i].op, vectors[i].a, vectors[i].b);
        if (e.value !== vectors[i].value || e.st !== vectors[i].st)
          report("table row", vectors[i].value, e.value);
      end
      send(vectors[i].op, vectors[i].a, vectors[i].b);
    end
    // unused opcodes
    send(4'hB, 32'd3, 32'd4);
    send(4'hF, FX_MAX, FX_MIN);

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 27 : 0;
      stall_pct = (ph == 2) ? 88 : (ph == 3) ? 27 : 0;
      for (int n = 0; n < 112; n++) begin
        a = rand_operand();
        b = ($urandom_range(9) == 0) ? a : rand_operand();
        if ($urandom_range(15) == 0) b = 32'd0;
        send(($urandom_range(19) == 0) ? 4'($urandom_range(15, 11)) : 4'($urandom_range(10)),
             a, b);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_fixed_point_alu_core: PASS");
    else
      $display("tb_fixed_point_alu_core: FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb_fixed_point_alu_core: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/fpa_pkg.sv
rtl/core/fpa_div.sv
rtl/core/fixed_point_alu_core.sv
rtl/core/fpa_checker.sv
verif/tb_fixed_point_alu_core.sv
